// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the obstacle finder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define SRJO_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// Same-cycle implication
`define SRJO_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

// Next-cycle implication
`define SRJO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ----- design/srjo_pkg.sv -----
// Types, constants and tables of the scan range jump obstacle finder
package srjo_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_N           = 24;

  // Configuration register indexes
  localparam logic [7:0] REG_REFERENCE_X       = 8'd0;
  localparam logic [7:0] REG_REFERENCE_Y       = 8'd1;
  localparam logic [7:0] REG_TOLERANCE_PERCENT = 8'd2;
  localparam logic [7:0] REG_REPORT_LIMIT      = 8'd3;

  // Register reset values
  localparam logic [15:0] REFERENCE_X_RST       = 16'd30000;
  localparam logic [15:0] REFERENCE_Y_RST       = 16'd0;
  localparam logic [6:0]  TOLERANCE_PERCENT_RST = 7'd5;
  localparam logic [15:0] REPORT_LIMIT_RST      = 16'd29800;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               first_of_scan;
  } point_t;

  typedef struct packed {
    logic [15:0]        obstacle_range;
    logic signed [15:0] obstacle_angle;
    logic [15:0]        obstacle_number;
  } obstacle_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] value;
  } cfg_t;

  // Magnitude of a 16-bit two's complement value
  function automatic logic [15:0] mag16(input logic [15:0] v);
    logic [15:0] m;
    m = v[15] ? (~v + 16'd1) : v;
    return m;
  endfunction

  // atan(2^-i) in 2^-16 centidegree units
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'd294912000;
      5'd1:  a = 32'd174096719;
      5'd2:  a = 32'd91987925;
      5'd3:  a = 32'd46694507;
      5'd4:  a = 32'd23437865;
      5'd5:  a = 32'd11730358;
      5'd6:  a = 32'd5866610;
      5'd7:  a = 32'd2933484;
      5'd8:  a = 32'd1466764;
      5'd9:  a = 32'd733385;
      5'd10: a = 32'd366693;
      5'd11: a = 32'd183346;
      5'd12: a = 32'd91673;
      5'd13: a = 32'd45837;
      5'd14: a = 32'd22918;
      5'd15: a = 32'd11459;
      5'd16: a = 32'd5730;
      5'd17: a = 32'd2865;
      5'd18: a = 32'd1432;
      5'd19: a = 32'd716;
      5'd20: a = 32'd358;
      5'd21: a = 32'd179;
      5'd22: a = 32'd90;
      5'd23: a = 32'd45;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- design/srjo_chan_if.sv -----
// Valid/ready channel carrying one word of a given payload type
interface srjo_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/scan_range_jump_obstacle_finder_unit.sv -----
// Top level of the scan range jump obstacle finder
//
// Channels: points (sink) takes one laser point word (x, y, z in mm and a
// first-of-scan flag); obstacles (source) gives one word per reported group:
// nearest range, signed angle to the reference vector in centidegrees and the
// running obstacle number; cfg takes register writes (index, value) and is
// always ready, but is only to be written while the block is idle.
// One point is handled at a time; points.ready is high only when idle.
// All arithmetic runs through one 32x32 multiplier with an accumulator, one
// bit-serial square root and one CORDIC stage, under a sequencer.
// Steps per point: for an ordinary point 3 squares, the root, 3 tolerance
// products, decide and finish; for the first point of a scan 3 squares and a
// root each for the point and for the reference length; when a group closes
// and is reported also 9 products, 2 wide products, a 64-bit root, up to 30
// normalising shifts and the CORDIC iterations.
// Results go into an output register; the block accepts the next point while
// a result waits. If the receiver stalls and a new result is ready, the
// sequencer holds in its last state until the output register frees.
// Reset (synchronous, rst high) restores the register defaults, clears the
// scan state (obstacle count to one) and drops the output word.
module scan_range_jump_obstacle_finder_unit
  import srjo_pkg::*;
#(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  srjo_chan_if.sink   points,
  srjo_chan_if.source obstacles,
  srjo_chan_if.sink   cfg
);

  localparam int COORD_W = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int EXT_SH  = 16 - COORD_W;
  localparam int CORD_N  = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
  localparam logic [4:0] CORD_LAST = 5'(CORD_N - 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SQP    = 13'b0000000000010,
    S_ROOTP  = 13'b0000000000100,
    S_SQR    = 13'b0000000001000,
    S_ROOTR  = 13'b0000000010000,
    S_TOL    = 13'b0000000100000,
    S_DECIDE = 13'b0000001000000,
    S_SQA    = 13'b0000010000000,
    S_PROD   = 13'b0000100000000,
    S_ROOTA  = 13'b0001000000000,
    S_NORM   = 13'b0010000000000,
    S_CORD   = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  state_t state;
  logic [3:0] step;
  logic [4:0] cnt;

  // latched point
  logic [15:0] px, py, pz;
  logic        first;
  logic [15:0] r;

  // configuration registers
  logic [15:0] reference_x, reference_y, report_limit;
  logic [6:0]  tolerance_percent;

  // scan state
  logic [15:0] previous_range, nearest_range, nearest_x, nearest_y, nearest_z;
  logic [15:0] reference_z, reference_length, obstacle_count;

  // arithmetic registers
  logic [63:0]        acc;
  logic [31:0]        r2, n2;
  logic signed [34:0] dot;
  logic [63:0]        sq_val, sq_res, sq_bit;
  logic [23:0]        t_prev, t_hi, t_lo;
  logic               lo_neg;
  logic               do_jump;
  logic signed [39:0] cx, cy;
  logic signed [31:0] cz;
  logic [4:0]         ci;

  // output register
  obstacle_t out_q;
  logic      out_valid;

  assign points.ready    = (state == S_IDLE);
  assign cfg.ready       = 1'b1;
  assign obstacles.valid = out_valid;
  assign obstacles.data  = out_q;

  // Sign extension of a coordinate from the configured width
  function automatic logic [15:0] ext_coord(input logic [15:0] v);
    logic [15:0] t;
    t = v << EXT_SH;
    return 16'($signed(t) >>> EXT_SH);
  endfunction

  // Right shift rounding toward zero
  function automatic logic signed [39:0] asr0(input logic signed [39:0] v,
                                              input logic [4:0] k);
    logic signed [39:0] n;
    n = -v;
    return (v >= 0) ? (v >>> k) : -(n >>> k);
  endfunction

  // Shared multiplier: operand selection
  logic [31:0] ma, mb;
  logic        m_neg;
  logic [63:0] prod;
  logic [7:0]  tol_hi, tol_lo;

  assign tol_hi = 8'd100 + {1'b0, tolerance_percent};
  assign tol_lo = (tolerance_percent > 7'd100) ? ({1'b0, tolerance_percent} - 8'd100)
                                               : (8'd100 - {1'b0, tolerance_percent});

  // magnitude of the dot product
  logic [31:0] adot;
  assign adot = dot[34] ? 32'(-dot) : dot[31:0];

  always_comb begin
    ma    = '0;
    mb    = '0;
    m_neg = 1'b0;
    unique case (state)
      S_SQP: begin
        case (step[1:0])
          2'd0:    ma = {16'd0, mag16(px)};
          2'd1:    ma = {16'd0, mag16(py)};
          default: ma = {16'd0, mag16(pz)};
        endcase
        mb = ma;
      end
      S_SQR: begin
        case (step[1:0])
          2'd0:    ma = {16'd0, mag16(reference_x)};
          2'd1:    ma = {16'd0, mag16(reference_y)};
          default: ma = {16'd0, mag16(pz)};
        endcase
        mb = ma;
      end
      S_TOL: begin
        case (step[1:0])
          2'd0: begin
            ma = {16'd0, previous_range};
            mb = 32'd100;
          end
          2'd1: begin
            ma = {16'd0, r};
            mb = {24'd0, tol_hi};
          end
          default: begin
            ma = {16'd0, r};
            mb = {24'd0, tol_lo};
          end
        endcase
      end
      S_SQA: begin
        case (step)
          4'd0: begin ma = {16'd0, mag16(reference_x)}; mb = ma; end
          4'd1: begin ma = {16'd0, mag16(reference_y)}; mb = ma; end
          4'd2: begin ma = {16'd0, mag16(reference_z)}; mb = ma; end
          4'd3: begin ma = {16'd0, mag16(nearest_x)};   mb = ma; end
          4'd4: begin ma = {16'd0, mag16(nearest_y)};   mb = ma; end
          4'd5: begin ma = {16'd0, mag16(nearest_z)};   mb = ma; end
          4'd6: begin
            ma    = {16'd0, mag16(reference_x)};
            mb    = {16'd0, mag16(nearest_x)};
            m_neg = reference_x[15] ^ nearest_x[15];
          end
          4'd7: begin
            ma    = {16'd0, mag16(reference_y)};
            mb    = {16'd0, mag16(nearest_y)};
            m_neg = reference_y[15] ^ nearest_y[15];
          end
          default: begin
            ma    = {16'd0, mag16(reference_z)};
            mb    = {16'd0, mag16(nearest_z)};
            m_neg = reference_z[15] ^ nearest_z[15];
          end
        endcase
      end
      S_PROD: begin
        if (step == 4'd0) begin
          ma = r2;
          mb = n2;
        end else begin
          ma = adot;
          mb = adot;
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  // Square root: one result bit per cycle
  logic [63:0] rb, sq_val_next, sq_res_next;
  logic        sq_ge;
  logic [15:0] root_sat;

  assign rb          = sq_res + sq_bit;
  assign sq_ge       = (sq_val >= rb);
  assign sq_val_next = sq_ge ? (sq_val - rb) : sq_val;
  assign sq_res_next = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
  assign root_sat    = (sq_res_next[63:16] != '0) ? 16'hFFFF : sq_res_next[15:0];

  // CORDIC vectoring step
  logic signed [39:0] xs, ys;
  logic signed [31:0] at;
  assign xs = asr0(cx, ci);
  assign ys = asr0(cy, ci);
  assign at = $signed(atan_entry(ci));

  // Jump test on the tolerance products
  logic jump;
  assign jump = (t_prev > t_hi) || (!lo_neg && (t_prev < t_lo));

  // Group the current point joins: a fresh group on a jump
  logic [15:0] g_range, g_x, g_y, g_z;
  logic        take;
  assign g_range = do_jump ? reference_length : nearest_range;
  assign g_x     = do_jump ? reference_x : nearest_x;
  assign g_y     = do_jump ? reference_y : nearest_y;
  assign g_z     = do_jump ? reference_z : nearest_z;
  assign take    = (r <= g_range);

  // Angle rounding, clamping, mirroring and sign
  logic signed [31:0] zc;
  logic [16:0]        cdw;
  logic [15:0]        cd, cdm;
  logic signed [15:0] angle;
  assign zc    = (cz < 0) ? 32'sd0 : cz;
  assign cdw   = 17'((zc + 32'sd32768) >>> 16);
  assign cd    = (cdw > 17'd9000) ? 16'd9000 : cdw[15:0];
  assign cdm   = dot[34] ? (16'd18000 - cd) : cd;
  assign angle = nearest_y[15] ? -$signed(cdm) : $signed(cdm);

  logic out_free;
  assign out_free = !out_valid || obstacles.ready;

  // closed group near enough to be reported
  logic report;
  assign report = do_jump && (nearest_range < report_limit);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_x       <= REFERENCE_X_RST;
      reference_y       <= REFERENCE_Y_RST;
      tolerance_percent <= TOLERANCE_PERCENT_RST;
      report_limit      <= REPORT_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_REFERENCE_X:       reference_x       <= cfg.data.value;
        REG_REFERENCE_Y:       reference_y       <= cfg.data.value;
        REG_TOLERANCE_PERCENT: tolerance_percent <= cfg.data.value[6:0];
        REG_REPORT_LIMIT:      report_limit      <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && report && out_free) begin
      out_valid <= 1'b1;
    end else if (obstacles.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && report && out_free) begin
      out_q.obstacle_range  <= nearest_range;
      out_q.obstacle_angle  <= angle;
      out_q.obstacle_number <= obstacle_count;
    end
  end

  // Sequencer and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      step             <= '0;
      cnt              <= '0;
      previous_range   <= '0;
      nearest_range    <= '0;
      nearest_x        <= '0;
      nearest_y        <= '0;
      nearest_z        <= '0;
      reference_z      <= '0;
      reference_length <= '0;
      obstacle_count   <= 16'd1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (points.valid) begin
            px    <= ext_coord(points.data.point_x);
            py    <= ext_coord(points.data.point_y);
            pz    <= ext_coord(points.data.point_z);
            first <= points.data.first_of_scan;
            acc   <= '0;
            step  <= '0;
            state <= S_SQP;
          end
        end

        // sum of squares, then start the root
        S_SQP, S_SQR: begin
          acc <= acc + prod;
          if (step == 4'd2) begin
            sq_val <= acc + prod;
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            cnt    <= '0;
            state  <= (state == S_SQP) ? S_ROOTP : S_ROOTR;
          end else begin
            step <= step + 4'd1;
          end
        end

        S_ROOTP, S_ROOTR, S_ROOTA: begin
          sq_val <= sq_val_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            step <= '0;
            acc  <= '0;
            if (state == S_ROOTP) begin
              r     <= root_sat;
              state <= first ? S_SQR : S_TOL;
            end else if (state == S_ROOTR) begin
              // first point of a scan: new reference, group holds the nearer of this point and the reference
              reference_z      <= pz;
              reference_length <= root_sat;
              obstacle_count   <= 16'd1;
              previous_range   <= r;
              if (r <= root_sat) begin
                nearest_range <= r;
                nearest_x     <= px;
                nearest_y     <= py;
                nearest_z     <= pz;
              end else begin
                nearest_range <= root_sat;
                nearest_x     <= reference_x;
                nearest_y     <= reference_y;
                nearest_z     <= pz;
              end
              state <= S_IDLE;
            end else begin
              cx    <= {8'd0, adot};
              cy    <= {8'd0, sq_res_next[31:0]};
              state <= S_NORM;
            end
          end
        end

        S_TOL: begin
          case (step[1:0])
            2'd0:    t_prev <= prod[23:0];
            2'd1:    t_hi   <= prod[23:0];
            default: begin
              t_lo   <= prod[23:0];
              lo_neg <= (tolerance_percent > 7'd100);
            end
          endcase
          if (step == 4'd2) begin
            state <= S_DECIDE;
          end else begin
            step <= step + 4'd1;
          end
        end

        S_DECIDE: begin
          do_jump <= jump;
          step    <= '0;
          dot     <= '0;
          if (jump && (nearest_range < report_limit)) begin
            state <= S_SQA;
          end else begin
            state <= S_FIN;
          end
        end

        // squared lengths and dot product of reference and nearest point
        S_SQA: begin
          if (step < 4'd3) begin
            r2 <= (step == 4'd0) ? prod[31:0] : (r2 + prod[31:0]);
          end else if (step < 4'd6) begin
            n2 <= (step == 4'd3) ? prod[31:0] : (n2 + prod[31:0]);
          end else begin
            dot <= m_neg ? (dot - $signed({3'd0, prod[31:0]}))
                         : (dot + $signed({3'd0, prod[31:0]}));
          end
          if (step == 4'd8) begin
            step <= '0;
            // a zero vector gives a zero dot product and angle zero
            if (r2 == '0 || n2 == '0) begin
              cz    <= '0;
              state <= S_FIN;
            end else begin
              state <= S_PROD;
            end
          end else begin
            step <= step + 4'd1;
          end
        end

        // r2*n2 - dot^2 into the root
        S_PROD: begin
          if (step == 4'd0) begin
            acc  <= prod;
            step <= 4'd1;
          end else begin
            sq_val <= acc - prod;
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            cnt    <= '0;
            state  <= S_ROOTA;
          end
        end

        S_NORM: begin
          if ((cx | cy) < 40'sd1073741824) begin
            cx <= cx <<< 1;
            cy <= cy <<< 1;
          end else begin
            ci    <= '0;
            cz    <= '0;
            state <= S_CORD;
          end
        end

        S_CORD: begin
          if (cy >= 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end
          ci <= ci + 5'd1;
          if (ci == CORD_LAST) begin
            state <= S_FIN;
          end
        end

        // report if due, then the point joins its group
        S_FIN: begin
          if (do_jump && (nearest_range < report_limit)) begin
            if (out_free) begin
              if (obstacle_count != 16'hFFFF) begin
                obstacle_count <= obstacle_count + 16'd1;
              end
            end
          end
          if (out_free || !(do_jump && (nearest_range < report_limit))) begin
            nearest_range  <= take ? r  : g_range;
            nearest_x      <= take ? px : g_x;
            nearest_y      <= take ? py : g_y;
            nearest_z      <= take ? pz : g_z;
            previous_range <= r;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/srjo_check.sv -----
// Port-level checker of the obstacle finder and its bind to the top level
`include "assert_macros.svh"

module srjo_check
  import srjo_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        points_valid,
  input logic        points_ready,
  input logic        obstacles_valid,
  input logic        obstacles_ready,
  input obstacle_t   obstacles_data
);

  // one point at a time: a taken word drops ready
  `SRJO_ASSERT_NEXT(a_busy_after_take, points_valid && points_ready, !points_ready)

  // a result only appears at the end of a point's work
  `SRJO_ASSERT_IMPLY(a_result_from_work, $rose(obstacles_valid), $past(!points_ready))

  // stalled result word holds
  `SRJO_ASSERT_NEXT(a_out_hold, obstacles_valid && !obstacles_ready,
                    obstacles_valid && $stable(obstacles_data))

  // number is never zero and angle stays within a half turn
  `SRJO_ASSERT_IMPLY(a_out_fields, obstacles_valid,
                     obstacles_data.obstacle_number != 16'd0 &&
                     $signed(obstacles_data.obstacle_angle) <= 16'sd18000 &&
                     $signed(obstacles_data.obstacle_angle) >= -16'sd18000)

endmodule

bind scan_range_jump_obstacle_finder_unit srjo_check u_srjo_check (
  .clk             (clk),
  .rst             (rst),
  .points_valid    (points.valid),
  .points_ready    (points.ready),
  .obstacles_valid (obstacles.valid),
  .obstacles_ready (obstacles.ready),
  .obstacles_data  (obstacles.data)
);

// ----- bench/scan_range_jump_obstacle_finder_unit_tb.sv -----
// Self-checking testbench of the obstacle finder: point words in, obstacle words checked
module scan_range_jump_obstacle_finder_unit_tb;
  import srjo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY_WAIT = 250;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int HOLD_LONG    = 3000;
  localparam int ANGLE_STEPS  = 16;
  localparam longint ATAN_CD[16] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837,
    22918, 11459};

  logic clk = 1'b0;
  logic rst = 1'b1;

  srjo_chan_if #(.T(point_t))    points_if ();
  srjo_chan_if #(.T(obstacle_t)) obstacles_if ();
  srjo_chan_if #(.T(cfg_t))      cfg_if ();

  scan_range_jump_obstacle_finder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .points    (points_if.sink),
    .obstacles (obstacles_if.source),
    .cfg       (cfg_if.sink)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Configuration and scan state of the predictor
  logic [15:0] ref_x, ref_y, rep_limit;
  logic [6:0]  tol_pct;
  logic [15:0] prev_rng, near_rng, near_x, near_y, near_z, ref_z, ref_len, obs_count;

  obstacle_t pending_obstacles[$];
  int        mismatches;
  int        cycle_count;
  int        rx_hold_cnt;
  bit        rx_long_hold;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sum_sq(longint a, longint b, longint c);
    return longint'(a * a) + longint'(b * b) + longint'(c * c);
  endfunction

  function automatic logic [15:0] range_mm(longint a, longint b, longint c);
    longint unsigned r;
    r = isqrt(sum_sq(a, b, c));
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  // Shift toward zero
  function automatic longint shr0(longint v, int k);
    return (v >= 0) ? (v >>> k) : -((-v) >>> k);
  endfunction

  // Unsigned angle in centidegrees between two vectors, via vectoring CORDIC
  function automatic int angle_cd(longint ax, longint ay, longint az,
                                  longint bx, longint by, longint bz);
    longint unsigned r2, n2, adot, s;
    longint dot, x, y, z, xs, ys;
    int cd;
    r2 = sum_sq(ax, ay, az);
    n2 = sum_sq(bx, by, bz);
    if (r2 == 0 || n2 == 0) return 0;
    dot = ax * bx + ay * by + az * bz;
    adot = (dot < 0) ? -dot : dot;
    s = isqrt(r2 * n2 - adot * adot);
    while ((adot | s) < (64'd1 << 30)) begin
      adot <<= 1;
      s <<= 1;
    end
    x = adot;
    y = s;
    z = 0;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      xs = shr0(x, i);
      ys = shr0(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z += ATAN_CD[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z -= ATAN_CD[i];
      end
    end
    if (z < 0) z = 0;
    cd = int'((z + 32768) >>> 16);
    if (cd > 9000) cd = 9000;
    if (dot < 0) cd = 18000 - cd;
    return cd;
  endfunction

  function automatic void open_group();
    near_rng = ref_len;
    near_x = ref_x;
    near_y = ref_y;
    near_z = ref_z;
  endfunction

  function automatic void take_nearer(logic [15:0] r, point_t p);
    if (r <= near_rng) begin
      near_rng = r;
      near_x = p.point_x;
      near_y = p.point_y;
      near_z = p.point_z;
    end
  endfunction

  function automatic void reset_finder();
    ref_x = REFERENCE_X_RST;
    ref_y = REFERENCE_Y_RST;
    tol_pct = TOLERANCE_PERCENT_RST;
    rep_limit = REPORT_LIMIT_RST;
    prev_rng = 0; near_rng = 0; near_x = 0; near_y = 0; near_z = 0;
    ref_z = 0; ref_len = 0; obs_count = 1;
  endfunction

  // Works out the obstacle a point closes, if any; returns 1 when one is due
  function automatic bit predict_point(point_t p, output obstacle_t o);
    logic [15:0] r;
    longint prev100, tp;
    bit jump, hit;
    int a;
    hit = 0;
    o = '0;
    r = range_mm(p.point_x, p.point_y, p.point_z);
    if (p.first_of_scan) begin
      ref_z = p.point_z;
      ref_len = range_mm($signed(ref_x), $signed(ref_y), p.point_z);
      obs_count = 1;
      prev_rng = r;
      open_group();
      take_nearer(r, p);
      return 0;
    end
    prev100 = longint'(prev_rng) * 100;
    tp = longint'(tol_pct);
    jump = prev100 > longint'(r) * (100 + tp) || prev100 < longint'(r) * (100 - tp);
    if (jump) begin
      if (near_rng < rep_limit) begin
        a = angle_cd($signed(ref_x), $signed(ref_y), $signed(ref_z),
                     $signed(near_x), $signed(near_y), $signed(near_z));
        if (near_y[15]) a = -a;
        o.obstacle_range = near_rng;
        o.obstacle_angle = a[15:0];
        o.obstacle_number = obs_count;
        if (obs_count < 16'hFFFF) obs_count++;
        hit = 1;
      end
      open_group();
    end
    take_nearer(r, p);
    prev_rng = r;
    return hit;
  endfunction

  // Mostly no gap, else a short one and now and then a long one; calm stretches with none
  function automatic int pick_gap();
    if (cycle_count[10]) return 0;
    if ($urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 19) < 17) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver ready, with random stalls and the odd long hold-off
  always @(posedge clk) begin
    if (rx_hold_cnt > 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
      obstacles_if.ready <= 1'b0;
    end else if (rx_long_hold) begin
      rx_long_hold = 1'b0;
      rx_hold_cnt <= HOLD_LONG;
      obstacles_if.ready <= 1'b0;
    end else begin
      int g;
      g = pick_gap();
      if (g > 0) begin
        rx_hold_cnt <= g - 1;
        obstacles_if.ready <= 1'b0;
      end else begin
        obstacles_if.ready <= 1'b1;
      end
    end
  end

  // Compare each obstacle word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && obstacles_if.valid && obstacles_if.ready) begin
      obstacle_t got, want;
      got = obstacles_if.data;
      if (pending_obstacles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected obstacle word: range %0d angle %0d number %0d",
                   got.obstacle_range, got.obstacle_angle, got.obstacle_number);
      end else begin
        want = pending_obstacles.pop_front();
        if (got.obstacle_range !== want.obstacle_range ||
            got.obstacle_angle !== want.obstacle_angle ||
            got.obstacle_number !== want.obstacle_number) begin
          mismatches++;
          if (mismatches <= 10)
            $display("obstacle mismatch: exp range %0d angle %0d number %0d, got %0d %0d %0d",
                     want.obstacle_range, want.obstacle_angle, want.obstacle_number,
                     got.obstacle_range, got.obstacle_angle, got.obstacle_number);
        end
      end
    end
  end

  // Offer one point word and predict its result once accepted
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic signed [15:0] z, input bit first);
    point_t p;
    obstacle_t o;
    int g;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    p.first_of_scan = first;
    g = pick_gap();
    if (g > 0) begin
      points_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    points_if.valid <= 1'b1;
    points_if.data <= p;
    do @(posedge clk); while (!points_if.ready);
    if (predict_point(p, o)) pending_obstacles = {pending_obstacles, o};
  endtask

  // Stop offering and let every expected word and any busy point finish
  task automatic drain();
    points_if.valid <= 1'b0;
    while (pending_obstacles.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  // One register write word; valid stays up for the caller to drop
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] v);
    cfg_t w;
    w.index = idx;
    w.value = v;
    cfg_if.valid <= 1'b1;
    cfg_if.data <= w;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_REFERENCE_X:       ref_x = v;
      REG_REFERENCE_Y:       ref_y = v;
      REG_TOLERANCE_PERCENT: tol_pct = v[6:0];
      REG_REPORT_LIMIT:      rep_limit = v;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] rx, input logic [15:0] ry,
                           input logic [6:0] tol, input logic [15:0] lim);
    drain();
    write_reg(REG_REFERENCE_X, rx);
    write_reg(REG_REFERENCE_Y, ry);
    write_reg(REG_TOLERANCE_PERCENT, {9'd0, tol});
    write_reg(REG_REPORT_LIMIT, lim);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // Points with no scan started, on the reset state
  task automatic test_before_scan();
    send_point(16'sd1000, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd5000, -16'sd300, 16'sd10, 1'b0);
    send_point(16'sd100, 16'sd20, 16'sd0, 1'b0);
  endtask

  // Field extremes, equal ranges, jumps up and down, negative y, points behind
  task automatic test_directed();
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd2000, -16'sd1500, 16'sd0, 1'b0);
    send_point(16'sd2000, 16'sd1500, 16'sd0, 1'b0);
    send_point(16'sd2010, -16'sd1490, 16'sd5, 1'b0);
    send_point(-16'sd8000, 16'sd100, 16'sd0, 1'b0);
    send_point(-16'sd8000, -16'sd400, 16'sd0, 1'b0);
    send_point(16'sd300, 16'sd0, -16'sd100, 1'b0);
    send_point(16'sd0, -16'sd20000, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd20000, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd29900, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd10000, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd29000, 16'sd0, 16'sd0, 1'b0);
  endtask

  // Zero reference vector gives angle zero
  task automatic test_zero_reference();
    configure(16'd0, 16'd0, 7'd5, 16'd65535);
    send_point(16'sd500, 16'sd500, 16'sd0, 1'b1);
    send_point(16'sd1000, -16'sd200, 16'sd0, 1'b0);
    send_point(16'sd4000, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd100, 16'sd0, 16'sd0, 1'b0);
  endtask

  // One scan of segments with near-constant range, plus some noise words
  task automatic random_scan(input int n_items, inout int sent);
    int bx, by, bz, k, seg;
    send_point(clamp16($urandom_range(0, 65535) - 32768),
               clamp16($urandom_range(0, 65535) - 32768),
               clamp16($urandom_range(0, 400) - 200), 1'b1);
    sent++;
    while (n_items > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), $urandom_range(0, 19) == 0);
        sent++;
        n_items--;
        continue;
      end
      k = ($urandom_range(0, 3) == 0) ? 30000 : 12000;
      bx = $urandom_range(0, 2 * k) - k;
      by = $urandom_range(0, 2 * k) - k;
      bz = $urandom_range(0, 2000) - 1000;
      k = 1 + (((bx < 0) ? -bx : bx) + ((by < 0) ? -by : by)) / 300;
      seg = $urandom_range(1, 7);
      repeat (seg) begin
        send_point(clamp16(bx + $urandom_range(0, 2 * k) - k),
                   clamp16(by + $urandom_range(0, 2 * k) - k),
                   clamp16(bz + $urandom_range(0, 2 * k) - k), 1'b0);
        sent++;
        n_items--;
      end
    end
  endtask

  // Receiver holds off while points keep coming, then the sender waits it out
  task automatic test_backpressure();
    int sent;
    sent = 0;
    configure(16'd30000, 16'd0, 7'd5, 16'd65535);
    rx_long_hold = 1'b1;
    random_scan(40, sent);
    drain();
  endtask

  task automatic test_random_settings();
    int sent;
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(16'd30000, 16'd0, 7'd5, 16'd29800);
        1: configure(16'h7FFF, 16'h8000, 7'd0, 16'd65535);
        2: configure(16'h8000, 16'h7FFF, 7'd127, 16'd40000);
        3: configure(16'd1000, 16'hFC18, 7'd100, 16'd0);
        4: configure(16'hFFFF, 16'd1, 7'd1, 16'd20000);
        default: configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           7'($urandom_range(0, 30)), 16'($urandom_range(10000, 65535)));
      endcase
      while (sent < (ph + 1) * 82) random_scan($urandom_range(10, 40), sent);
    end
  endtask

  initial begin
    reset_finder();
    mismatches = 0;
    cycle_count = 0;
    rx_hold_cnt = 0;
    rx_long_hold = 1'b0;
    points_if.valid = 1'b0;
    points_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    obstacles_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_scan();
    test_directed();
    test_zero_reference();
    test_backpressure();
    test_random_settings();
    drain();
    if (mismatches == 0 && pending_obstacles.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/srjo_pkg.sv
design/srjo_chan_if.sv
design/scan_range_jump_obstacle_finder_unit.sv
design/srjo_check.sv
bench/scan_range_jump_obstacle_finder_unit_tb.sv
